>>> hw/rtl/cpa_pkg.sv
`timescale 1ns / 1ps

package cpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int PFN_W     = 52;
    localparam int CNT_W     = 13;
    localparam int ST_W      = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [OFF_W-1:0]     t_off;
    typedef logic [PFN_W-1:0]     t_pfn;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ST_W-1:0]      t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOSPACE = 2'd1;
    localparam t_status ST_DOUBLE  = 2'd2;
    localparam t_status ST_BAD     = 2'd3;

    typedef struct packed {
        logic invert;
        t_off lo;
        t_off hi;
    } t_bu_ctl;

    typedef struct packed {
        logic  found;
        t_off  pos;
        t_word mask;
    } t_bu_res;

    function automatic t_off first_one(input t_word w);
        t_off pos;
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (w[k]) begin
                pos = OFF_W'(k);
            end
        end
        return pos;
    endfunction

endpackage

>>> hw/rtl/cpa_req_if.sv
`timescale 1ns / 1ps

interface cpa_req_if;
    logic          valid;
    logic          ready;
    logic          action;
    cpa_pkg::t_cnt page_count;
    cpa_pkg::t_pfn free_page;

    modport source(output valid, action, page_count, free_page, input ready);
    modport sink(input valid, action, page_count, free_page, output ready);
endinterface

>>> hw/rtl/cpa_rsp_if.sv
`timescale 1ns / 1ps

interface cpa_rsp_if;
    logic             valid;
    logic             ready;
    cpa_pkg::t_status status;
    cpa_pkg::t_pfn    alloc_page;

    modport source(output valid, status, alloc_page, input ready);
    modport sink(input valid, status, alloc_page, output ready);
endinterface

>>> hw/rtl/cpa_ram.sv
`timescale 1ns / 1ps

module cpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cpa_bit_unit.sv
`timescale 1ns / 1ps

module cpa_bit_unit (
    input  cpa_pkg::t_word   i_word,
    input  cpa_pkg::t_bu_ctl i_ctl,
    output cpa_pkg::t_bu_res o_res
);

    cpa_pkg::t_word lo_mask;
    cpa_pkg::t_word hi_mask;
    cpa_pkg::t_word scan;

    always_comb begin
        lo_mask     = {cpa_pkg::WORD_BITS{1'b1}} << i_ctl.lo;
        hi_mask     = {cpa_pkg::WORD_BITS{1'b1}}
                      >> (cpa_pkg::OFF_W'(cpa_pkg::WORD_BITS - 1) - i_ctl.hi);
        scan        = (i_ctl.invert ? ~i_word : i_word) & lo_mask;
        o_res.found = |scan;
        o_res.pos   = cpa_pkg::first_one(scan);
        o_res.mask  = lo_mask & hi_mask;
    end

endmodule

>>> hw/rtl/contiguous_page_allocator.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   action, page_count, free_page
// o_rsp     out  valid/ready   status, alloc_page
// i_cfg     in   write enable  base_page
//
// After reset the used map is cleared one word per cycle, all ceil(NUM_PAGES/32) words,
// while i_req.ready stays low. One request is worked at a time, and ready is high only
// when idle. An allocate scans the map with the shared bit unit, one step per map word
// or per free/used boundary, then reads and rewrites each word that it marks. A free
// reads and rewrites each word that it touches; both end in the result state. The cost
// is set by the single map RAM and its registered read. A stalled response holds the
// next result in the sequencer until the output register frees up.

module contiguous_page_allocator #(
    parameter int NUM_PAGES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpa_req_if.sink           i_req,
    cpa_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  cpa_pkg::t_pfn     i_cfg_base_page
);

    localparam int DEPTH = (NUM_PAGES + cpa_pkg::WORD_BITS - 1) / cpa_pkg::WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AW + cpa_pkg::OFF_W + 1;
    localparam int OW    = cpa_pkg::OFF_W;

    localparam logic [PW-1:0] NUM_P  = PW'(NUM_PAGES);
    localparam logic [AW-1:0] LAST_W = AW'(DEPTH - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_FCHK = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_EV   = 4'd5;
    localparam logic [3:0] S_MRD  = 4'd6;
    localparam logic [3:0] S_MWR  = 4'd7;
    localparam logic [3:0] S_RES  = 4'd8;

    logic [3:0]          r_state, n_state;
    cpa_pkg::t_pfn       r_base, n_base;
    logic [PW-1:0]       r_resv, n_resv;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_ov, n_ov;

    logic                r_act, n_act;
    cpa_pkg::t_cnt       r_cnt, n_cnt;
    cpa_pkg::t_pfn       r_fpage, n_fpage;
    logic [cpa_pkg::PFN_W:0] r_diff, n_diff;
    logic [PW-1:0]       r_want, n_want;
    logic [PW-1:0]       r_i, n_i;
    logic [PW-1:0]       r_start, n_start;
    logic                r_used, n_used;
    logic [PW-1:0]       r_p, n_p;
    logic [PW-1:0]       r_e, n_e;
    logic                r_dbl, n_dbl;
    cpa_pkg::t_status    r_st, n_st;
    cpa_pkg::t_pfn       r_page, n_page;
    cpa_pkg::t_status    r_ost, n_ost;
    cpa_pkg::t_pfn       r_opage, n_opage;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    cpa_pkg::t_word      ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    cpa_pkg::t_word      ram_rdata;

    cpa_pkg::t_bu_ctl    bu_ctl;
    cpa_pkg::t_bu_res    bu_res;

    logic [31:0]         cnt32;
    logic [31:0]         free_end32;
    logic [PW-1:0]       seg_base, seg_end, lim, hit, hit_nx;
    logic                ext, succ, hit_ok, ext_fit;
    logic [PW:0]         run_e, run_last, ext_e;
    logic [PW-1:0]       ext_start;
    logic [PW-1:0]       p_base, p_next, last_pg;
    logic                same_word, mark_done;
    cpa_pkg::t_off       hi_off;

    cpa_ram #(
        .WIDTH(cpa_pkg::WORD_BITS),
        .DEPTH(DEPTH)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    cpa_bit_unit u_bits (
        .i_word(ram_rdata),
        .i_ctl (bu_ctl),
        .o_res (bu_res)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_ost;
    assign o_rsp.alloc_page = r_opage;

    always_comb begin
        cnt32      = 32'(r_cnt);
        free_end32 = 32'(r_diff[PW-1:0]) + cnt32;

        seg_base = {r_i[PW-1:OW], OW'(0)};
        seg_end  = seg_base + PW'(cpa_pkg::WORD_BITS);
        lim      = (seg_end < NUM_P) ? seg_end : NUM_P;
        hit      = bu_res.found ? (seg_base + PW'(bu_res.pos)) : seg_end;
        hit_nx   = hit + PW'(1);
        hit_ok   = bu_res.found && (hit < NUM_P);
        run_e    = {1'b0, r_start} + {1'b0, r_want};
        run_last = run_e - (PW + 1)'(1);
        ext      = (r_resv < lim) && (r_resv <= hit)
                   && (r_used || ({1'b0, r_resv} <= run_last));
        succ     = !r_used && (run_last < {1'b0, hit}) && (run_last < {1'b0, lim});
        ext_start = r_used ? r_resv : r_start;
        ext_e    = {1'b0, ext_start} + {1'b0, r_want};
        ext_fit  = (ext_e <= {1'b0, NUM_P});

        p_base    = {r_p[PW-1:OW], OW'(0)};
        p_next    = p_base + PW'(cpa_pkg::WORD_BITS);
        last_pg   = r_e - PW'(1);
        same_word = (last_pg[PW-1:OW] == r_p[PW-1:OW]);
        hi_off    = same_word ? last_pg[OW-1:0] : {OW{1'b1}};
        mark_done = (p_next >= r_e);

        bu_ctl.invert = (r_state == S_EV) && r_used;
        bu_ctl.lo     = (r_state == S_MWR) ? r_p[OW-1:0] : r_i[OW-1:0];
        bu_ctl.hi     = hi_off;
    end

    always_comb begin
        n_state = r_state;
        n_base  = i_cfg_we ? i_cfg_base_page : r_base;
        n_resv  = r_resv;
        n_clr   = r_clr;
        n_ov    = (r_ov && o_rsp.ready) ? 1'b0 : r_ov;
        n_act   = r_act;
        n_cnt   = r_cnt;
        n_fpage = r_fpage;
        n_diff  = r_diff;
        n_want  = r_want;
        n_i     = r_i;
        n_start = r_start;
        n_used  = r_used;
        n_p     = r_p;
        n_e     = r_e;
        n_dbl   = r_dbl;
        n_st    = r_st;
        n_page  = r_page;
        n_ost   = r_ost;
        n_opage = r_opage;

        ram_we    = 1'b0;
        ram_waddr = r_p[PW-2:OW];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_i[PW-2:OW];

        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_W) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_cnt   = i_req.page_count;
                    n_fpage = i_req.free_page;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_page = '0;
                n_st   = cpa_pkg::ST_BAD;
                if (r_cnt == '0) begin
                    n_state = S_RES;
                end else if (r_act == cpa_pkg::ACT_ALLOC) begin
                    if (cnt32 > 32'(NUM_PAGES)) begin
                        n_state = S_RES;
                    end else begin
                        n_want  = cnt32[PW-1:0];
                        n_i     = '0;
                        n_start = '0;
                        n_used  = 1'b0;
                        n_state = S_RD;
                    end
                end else begin
                    n_diff  = {1'b0, r_fpage} - {1'b0, r_base};
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (r_diff[cpa_pkg::PFN_W]
                    || (r_diff[cpa_pkg::PFN_W-1:0] >= cpa_pkg::PFN_W'(NUM_PAGES))
                    || (free_end32 > 32'(NUM_PAGES))) begin
                    n_st    = cpa_pkg::ST_BAD;
                    n_state = S_RES;
                end else begin
                    n_p     = r_diff[PW-1:0];
                    n_e     = free_end32[PW-1:0];
                    n_dbl   = 1'b0;
                    n_state = S_MRD;
                end
            end
            S_RD: begin
                if (r_i >= NUM_P) begin
                    n_st    = cpa_pkg::ST_NOSPACE;
                    n_page  = '0;
                    n_state = S_RES;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_EV;
                end
            end
            S_EV: begin
                if (ext) begin
                    if (ext_fit) begin
                        n_start = ext_start;
                        n_p     = ext_start;
                        n_e     = ext_e[PW-1:0];
                        n_resv  = ext_e[PW-1:0];
                        n_state = S_MRD;
                    end else begin
                        n_st    = cpa_pkg::ST_NOSPACE;
                        n_page  = '0;
                        n_state = S_RES;
                    end
                end else if (succ) begin
                    n_p     = r_start;
                    n_e     = run_e[PW-1:0];
                    n_state = S_MRD;
                end else if (hit_ok) begin
                    n_used  = !r_used;
                    n_i     = r_used ? hit : hit_nx;
                    n_start = r_used ? hit : hit_nx;
                    n_state = S_RD;
                end else begin
                    n_i     = seg_end;
                    n_start = r_used ? seg_end : r_start;
                    n_state = S_RD;
                end
            end
            S_MRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_p[PW-2:OW];
                n_state   = S_MWR;
            end
            S_MWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_p[PW-2:OW];
                if (r_act == cpa_pkg::ACT_FREE) begin
                    ram_wdata = ram_rdata & ~bu_res.mask;
                end else begin
                    ram_wdata = ram_rdata | bu_res.mask;
                end
                n_dbl = r_dbl || (|(~ram_rdata & bu_res.mask));
                n_p   = p_next;
                if (mark_done) begin
                    if (r_act == cpa_pkg::ACT_FREE) begin
                        n_page = '0;
                        n_st   = n_dbl ? cpa_pkg::ST_DOUBLE : cpa_pkg::ST_OK;
                    end else begin
                        n_page = r_base + cpa_pkg::PFN_W'(r_start);
                        n_st   = cpa_pkg::ST_OK;
                    end
                    n_state = S_RES;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_RES: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_ost   = r_st;
                    n_opage = r_page;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_base  <= '0;
            r_resv  <= PW'(1);
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_resv  <= n_resv;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_cnt   <= n_cnt;
        r_fpage <= n_fpage;
        r_diff  <= n_diff;
        r_want  <= n_want;
        r_i     <= n_i;
        r_start <= n_start;
        r_used  <= n_used;
        r_p     <= n_p;
        r_e     <= n_e;
        r_dbl   <= n_dbl;
        r_st    <= n_st;
        r_page  <= n_page;
        r_ost   <= n_ost;
        r_opage <= n_opage;
    end

endmodule

>>> tb/sv/contiguous_page_allocator_checker.sv
`timescale 1ns / 1ps

module contiguous_page_allocator_checker #(
    parameter int NUM_PAGES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpa_req_if            i_req,
    cpa_rsp_if            i_rsp,
    input  logic          i_cfg_we,
    input  cpa_pkg::t_pfn i_cfg_base_page,
    output int            o_mismatches,
    output int            o_outstanding,
    output int            o_answers
);

    typedef struct packed {
        cpa_pkg::t_status status;
        cpa_pkg::t_pfn    page;
    } t_answer;

    t_answer              expected_answers[$];
    bit [NUM_PAGES-1:0]   page_used;
    int                   watermark;
    cpa_pkg::t_pfn        base_page;
    int                   mismatches = 0;
    int                   answers = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    function automatic void mark_used(input int first, input int len);
        for (int k = 0; k < len; k++) begin
            page_used[first + k] = 1'b1;
        end
    endfunction

    // First fit below the watermark; a run that reaches the watermark is
    // completed with untouched pages and moves the watermark to its end.
    function automatic void claim_run(input int want, output cpa_pkg::t_status status,
                                      output cpa_pkg::t_pfn page);
        int run_len;
        int run_start;
        status    = cpa_pkg::ST_NOSPACE;
        page      = '0;
        run_len   = 0;
        run_start = 0;
        if (want == 0 || want > NUM_PAGES) begin
            status = cpa_pkg::ST_BAD;
            return;
        end
        for (int p = 0; p < NUM_PAGES; p++) begin
            if (p >= watermark) begin
                if (run_start + want <= NUM_PAGES) begin
                    mark_used(run_start, want);
                    watermark = run_start + want;
                    status    = cpa_pkg::ST_OK;
                    page      = base_page + cpa_pkg::t_pfn'(run_start);
                end
                return;
            end
            if (page_used[p]) begin
                run_len   = 0;
                run_start = p + 1;
            end else begin
                run_len++;
                if (run_len == want) begin
                    mark_used(run_start, want);
                    status = cpa_pkg::ST_OK;
                    page   = base_page + cpa_pkg::t_pfn'(run_start);
                    return;
                end
            end
        end
    endfunction

    function automatic cpa_pkg::t_status release_run(input cpa_pkg::t_pfn page,
                                                     input int count);
        longint unsigned offset;
        bit              was_free;
        was_free = 1'b0;
        if (count == 0 || page < base_page) begin
            return cpa_pkg::ST_BAD;
        end
        offset = 64'(page - base_page);
        if (offset >= NUM_PAGES || offset + count > NUM_PAGES) begin
            return cpa_pkg::ST_BAD;
        end
        for (int k = 0; k < count; k++) begin
            if (!page_used[int'(offset) + k]) begin
                was_free = 1'b1;
            end
            page_used[int'(offset) + k] = 1'b0;
        end
        return was_free ? cpa_pkg::ST_DOUBLE : cpa_pkg::ST_OK;
    endfunction

    always @(posedge i_clk) begin
        t_answer predicted;
        t_answer oldest;
        if (!i_rst_n) begin
            page_used = '0;
            watermark = 1;
            base_page = '0;
            expected_answers.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == cpa_pkg::ACT_ALLOC) begin
                    claim_run(int'(i_req.page_count), predicted.status, predicted.page);
                end else begin
                    predicted.status = release_run(i_req.free_page, int'(i_req.page_count));
                    predicted.page   = '0;
                end
                expected_answers.push_back(predicted);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("answer with no request waiting: status %0d page %h",
                                              i_rsp.status, i_rsp.alloc_page));
                end else begin
                    oldest = expected_answers.pop_front();
                    answers++;
                    if (i_rsp.status !== oldest.status) begin
                        report_mismatch($sformatf("status mismatch: expected %0d, got %0d",
                                                  oldest.status, i_rsp.status));
                    end
                    if (i_rsp.alloc_page !== oldest.page) begin
                        report_mismatch($sformatf("alloc_page mismatch: expected %h, got %h",
                                                  oldest.page, i_rsp.alloc_page));
                    end
                end
            end
            if (i_cfg_we) begin
                base_page = i_cfg_base_page;
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_answers.size();
        o_answers     <= answers;
    end

endmodule

>>> tb/sv/contiguous_page_allocator_tb.sv
`timescale 1ns / 1ps

module contiguous_page_allocator_tb;

    localparam int            NUM_PAGES    = 4096;
    localparam int            RANDOM_ITEMS = 500;
    localparam int            PHASES       = 5;
    localparam int            CYCLE_LIMIT  = 20_000_000;
    localparam int            DRAIN_CYCLES = 300;
    localparam cpa_pkg::t_pfn PFN_MAX      = '1;

    typedef struct {
        int first;
        int len;
    } t_run;

    typedef struct packed {
        logic          action;
        cpa_pkg::t_cnt count;
    } t_sent;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_we;
    cpa_pkg::t_pfn cfg_base;

    int   chk_mismatches;
    int   chk_outstanding;
    int   chk_answers;

    t_run          live_runs[$];
    t_sent         sent_log[$];
    cpa_pkg::t_pfn base_now;
    bit            jitter;
    int            cycles = 0;
    int            n_alloc;
    int            n_free;
    int            n_bases;
    int            status_seen[4] = '{default: 0};

    cpa_req_if req();
    cpa_rsp_if rsp();

    contiguous_page_allocator #(
        .NUM_PAGES(NUM_PAGES)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req          (req),
        .o_rsp          (rsp),
        .i_cfg_we       (cfg_we),
        .i_cfg_base_page(cfg_base)
    );

    contiguous_page_allocator_checker #(
        .NUM_PAGES(NUM_PAGES)
    ) i_answer_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req          (req),
        .i_rsp          (rsp),
        .i_cfg_we       (cfg_we),
        .i_cfg_base_page(cfg_base),
        .o_mismatches   (chk_mismatches),
        .o_outstanding  (chk_outstanding),
        .o_answers      (chk_answers)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        rsp.ready <= !jitter || ($urandom_range(99) >= 33);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("contiguous_page_allocator_tb: FAIL");
            $finish;
        end
    end

    // Successful allocations feed the pool of runs that later free requests target.
    always @(negedge clk) begin
        t_sent sent;
        if (rsp.valid && rsp.ready && sent_log.size() != 0) begin
            sent = sent_log.pop_front();
            status_seen[rsp.status]++;
            if (sent.action == cpa_pkg::ACT_ALLOC && rsp.status == cpa_pkg::ST_OK) begin
                live_runs.push_back('{int'(cpa_pkg::t_pfn'(rsp.alloc_page - base_now)),
                                      int'(sent.count)});
            end
        end
    end

    task automatic send_request(input logic act, input cpa_pkg::t_cnt count,
                                input cpa_pkg::t_pfn page);
        while (jitter && $urandom_range(99) < 33) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.action     <= act;
        req.page_count <= count;
        req.free_page  <= page;
        @(posedge clk);
        while (!req.ready) begin
            @(posedge clk);
        end
        sent_log.push_back('{act, count});
        if (act == cpa_pkg::ACT_ALLOC) begin
            n_alloc++;
        end else begin
            n_free++;
        end
    endtask

    task automatic write_base(input cpa_pkg::t_pfn value);
        req.valid <= 1'b0;
        @(posedge clk);
        while (chk_outstanding != 0 || !req.ready) begin
            @(posedge clk);
        end
        cfg_we   <= 1'b1;
        cfg_base <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        base_now = value;
        n_bases++;
    endtask

    task automatic random_request();
        int            pick;
        int            roll;
        int            idx;
        int            first;
        t_run          run;
        cpa_pkg::t_cnt count;
        pick = $urandom_range(99);
        if (live_runs.size() == 0 || pick < 45) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                count = cpa_pkg::t_cnt'($urandom_range(8, 1));
            end else if (roll < 85) begin
                count = cpa_pkg::t_cnt'($urandom_range(64, 9));
            end else if (roll < 95) begin
                count = cpa_pkg::t_cnt'($urandom_range(512, 65));
            end else begin
                count = cpa_pkg::t_cnt'($urandom_range(NUM_PAGES, 513));
            end
            send_request(cpa_pkg::ACT_ALLOC, count, cpa_pkg::t_pfn'({$urandom, $urandom}));
        end else if (pick < 85) begin
            idx = $urandom_range(live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            if ($urandom_range(99) < 85) begin
                send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(run.len),
                             base_now + cpa_pkg::t_pfn'(run.first));
            end else begin
                first = run.first + $urandom_range(8) - 4;
                if (first < 0) begin
                    first = 0;
                end
                count = cpa_pkg::t_cnt'($urandom_range(run.len + 8, 1));
                send_request(cpa_pkg::ACT_FREE, count, base_now + cpa_pkg::t_pfn'(first));
            end
        end else begin
            case ($urandom_range(3))
                0: begin
                    count = ($urandom_range(1) == 0)
                            ? cpa_pkg::t_cnt'(0)
                            : cpa_pkg::t_cnt'($urandom_range(8191, NUM_PAGES + 1));
                    send_request(cpa_pkg::ACT_ALLOC, count,
                                 cpa_pkg::t_pfn'({$urandom, $urandom}));
                end
                1: send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'($urandom),
                                cpa_pkg::t_pfn'({$urandom, $urandom}));
                2: send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(0),
                                base_now + cpa_pkg::t_pfn'($urandom_range(NUM_PAGES - 1)));
                default: send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1),
                                      base_now - cpa_pkg::t_pfn'($urandom_range(16, 1)));
            endcase
        end
    endtask

    initial begin
        cpa_pkg::t_pfn phase_base;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_base       = '0;
        req.valid      = 1'b0;
        req.action     = cpa_pkg::ACT_ALLOC;
        req.page_count = '0;
        req.free_page  = '0;
        jitter         = 1'b1;
        base_now       = '0;
        n_alloc        = 0;
        n_free         = 0;
        n_bases        = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(0), '0);
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(0), '0);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(NUM_PAGES + 1), '0);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(8191), PFN_MAX);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(1), '0);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(3), '0);
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1), cpa_pkg::t_pfn'(0));
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1), cpa_pkg::t_pfn'(0));
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(3), cpa_pkg::t_pfn'(2));
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1), cpa_pkg::t_pfn'(NUM_PAGES));
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(2), cpa_pkg::t_pfn'(NUM_PAGES - 1));
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1), cpa_pkg::t_pfn'(NUM_PAGES - 1));
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(8191), PFN_MAX);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(NUM_PAGES), '0);
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1), cpa_pkg::t_pfn'(1));
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(2), '0);
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(2), cpa_pkg::t_pfn'(0));

        write_base(PFN_MAX);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(1), '0);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(1), '0);
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1), PFN_MAX);
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(1), cpa_pkg::t_pfn'(0));

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       phase_base = cpa_pkg::t_pfn'({$urandom, $urandom});
                1:       phase_base = '0;
                2:       phase_base = PFN_MAX;
                3:       phase_base = cpa_pkg::t_pfn'($urandom_range(1 << 20));
                default: phase_base = cpa_pkg::t_pfn'({$urandom, $urandom});
            endcase
            write_base(phase_base);
            jitter = (phase != 1);
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
                random_request();
            end
        end

        // Clear the whole map, fill it with one run, show it is full, then free it again.
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(NUM_PAGES), base_now);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(NUM_PAGES), '0);
        send_request(cpa_pkg::ACT_ALLOC, cpa_pkg::t_cnt'(1), '0);
        send_request(cpa_pkg::ACT_FREE, cpa_pkg::t_cnt'(NUM_PAGES), base_now);
        req.valid <= 1'b0;

        @(posedge clk);
        while (chk_outstanding != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d allocate, %0d free) under %0d base page settings.",
                 n_alloc + n_free, n_alloc, n_free, n_bases);
        $display("Checked %0d answers: %0d ok, %0d no space, %0d double free, %0d bad request.",
                 chk_answers, status_seen[cpa_pkg::ST_OK], status_seen[cpa_pkg::ST_NOSPACE],
                 status_seen[cpa_pkg::ST_DOUBLE], status_seen[cpa_pkg::ST_BAD]);
        if (chk_mismatches == 0 && chk_outstanding == 0) begin
            $display("contiguous_page_allocator_tb: PASS");
        end else begin
            $display("contiguous_page_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule
